// ===== hw/rtl/dfw_pkg.sv =====
`default_nettype none

package dfw_pkg;

   // Ticks between two health checks.
   localparam int CheckPeriod = 100;
   localparam int CntWidth    = $clog2(CheckPeriod + 1);

   localparam int AgeWidth = 17;
   localparam int TmoWidth = 16;

   localparam logic [AgeWidth-1:0] AgeMax = {AgeWidth{1'b1}};

   typedef logic [AgeWidth-1:0] age_type;
   typedef logic [CntWidth-1:0] cnt_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      RegFirstTimeout    = 2'd0,
      RegSecondTimeout   = 2'd1,
      RegLossMode        = 2'd2,
      RegEscalateTimeout = 2'd3
   } reg_index_type;

   // Loss modes.
   localparam logic [1:0] ModeLoiterLand = 2'd0;
   localparam logic [1:0] ModeLand       = 2'd1;

   // Health codes.
   localparam logic [1:0] HealthOk         = 2'd0;
   localparam logic [1:0] HealthFirstLost  = 2'd1;
   localparam logic [1:0] HealthSecondLost = 2'd2;
   localparam logic [1:0] HealthBothLost   = 2'd3;

   // Action codes.
   localparam logic [1:0] ActNone   = 2'd0;
   localparam logic [1:0] ActLoiter = 2'd1;
   localparam logic [1:0] ActLand   = 2'd2;

   localparam logic [TmoWidth-1:0] FirstTimeoutReset    = 16'd500;
   localparam logic [TmoWidth-1:0] SecondTimeoutReset   = 16'd500;
   localparam logic [1:0]          LossModeReset        = 2'd0;
   localparam logic [TmoWidth-1:0] EscalateTimeoutReset = 16'd5000;

   typedef struct packed {
      logic [TmoWidth-1:0] first_timeout;
      logic [TmoWidth-1:0] second_timeout;
      logic [1:0]          loss_mode;
      logic [TmoWidth-1:0] escalate_timeout;
   } cfg_type;

   typedef struct packed {
      logic tick;
      logic first_feed;
      logic second_feed;
   } item_type;

   typedef struct packed {
      logic [1:0] health;
      logic [1:0] action_request;
      logic       alert;
      logic       failsafe_active;
   } result_type;

   function automatic age_type sat_inc(age_type v);
      sat_inc = (v == AgeMax) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dfw_csr.sv =====
`default_nettype none

module dfw_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   output dfw_pkg::cfg_type       cfg
);
   import dfw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            RegFirstTimeout:    cfg_in.first_timeout    = csr_wdata;
            RegSecondTimeout:   cfg_in.second_timeout   = csr_wdata;
            RegLossMode:        cfg_in.loss_mode        = csr_wdata[1:0];
            RegEscalateTimeout: cfg_in.escalate_timeout = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_timeout    <= FirstTimeoutReset;
         cfg_ff.second_timeout   <= SecondTimeoutReset;
         cfg_ff.loss_mode        <= LossModeReset;
         cfg_ff.escalate_timeout <= EscalateTimeoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dfw_core.sv =====
`default_nettype none

module dfw_core (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           fire,
   input  dfw_pkg::item_type   item,
   input  dfw_pkg::cfg_type    cfg,
   output dfw_pkg::result_type result
);
   import dfw_pkg::*;

   age_type    first_age_ff, first_age_in;
   age_type    second_age_ff, second_age_in;
   age_type    elapsed_ff, elapsed_in;
   cnt_type    count_ff, count_in;
   logic [1:0] health_ff, health_in;
   logic       latch_ff, latch_in;

   age_type    first_age_t, second_age_t, elapsed_t;
   cnt_type    count_inc;
   logic       check;
   logic       ok_first, ok_second;
   logic [1:0] fresh;
   logic       new_loss;
   logic       latch_t;
   logic [1:0] action;

   always_comb begin
      // advance ages on a tick, then drop them on a feed
      first_age_t  = item.tick ? sat_inc(first_age_ff) : first_age_ff;
      second_age_t = item.tick ? sat_inc(second_age_ff) : second_age_ff;
      if (item.first_feed) begin
         first_age_t = '0;
      end
      if (item.second_feed) begin
         second_age_t = '0;
      end
      elapsed_t = (item.tick && latch_ff) ? sat_inc(elapsed_ff) : elapsed_ff;

      count_inc = count_ff + 1'b1;
      check     = item.tick && (count_inc >= CntWidth'(CheckPeriod));
      count_in  = item.tick ? (check ? '0 : count_inc) : count_ff;

      ok_first  = first_age_t <= {1'b0, cfg.first_timeout};
      ok_second = second_age_t <= {1'b0, cfg.second_timeout};
      priority if (!ok_first && !ok_second) begin
         fresh = HealthBothLost;
      end else if (!ok_first) begin
         fresh = HealthFirstLost;
      end else if (!ok_second) begin
         fresh = HealthSecondLost;
      end else begin
         fresh = HealthOk;
      end

      health_in     = health_ff;
      latch_in      = latch_ff;
      elapsed_in    = elapsed_t;
      action        = ActNone;
      new_loss      = 1'b0;
      latch_t       = latch_ff;
      first_age_in  = first_age_t;
      second_age_in = second_age_t;

      if (check) begin
         health_in = fresh;
         new_loss  = (fresh != HealthOk) && (health_ff == HealthOk);
         if (new_loss) begin
            action     = (cfg.loss_mode == ModeLand) ? ActLand : ActLoiter;
            elapsed_in = '0;
            latch_t    = 1'b1;
         end
         if (fresh == HealthOk) begin
            latch_t = 1'b0;
         end
         // escalate a long loiter failsafe to landing
         if (latch_t && (cfg.loss_mode == ModeLoiterLand) &&
             (elapsed_in > {1'b0, cfg.escalate_timeout})) begin
            action  = ActLand;
            latch_t = 1'b0;
         end
         latch_in = latch_t;
      end

      result.health          = health_in;
      result.action_request  = action;
      result.alert           = new_loss;
      result.failsafe_active = latch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_age_ff  <= '0;
         second_age_ff <= '0;
         elapsed_ff    <= '0;
         count_ff      <= '0;
         health_ff     <= HealthOk;
         latch_ff      <= 1'b0;
      end else if (fire) begin
         first_age_ff  <= first_age_in;
         second_age_ff <= second_age_in;
         elapsed_ff    <= elapsed_in;
         count_ff      <= count_in;
         health_ff     <= health_in;
         latch_ff      <= latch_in;
      end
   end

   a_alert_sets_action: assert property (@(posedge clock) disable iff (reset)
      fire && result.alert |-> result.action_request != ActNone && result.failsafe_active)
      else $error("alert without action or failsafe");

   a_no_tick_no_check: assert property (@(posedge clock) disable iff (reset)
      fire && !item.tick |-> result.action_request == ActNone && !result.alert)
      else $error("check outside a tick");

   a_latch_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(latch_ff) && $stable(health_ff))
      else $error("state moved without an item");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < CntWidth'(CheckPeriod))
      else $error("check counter out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/dual_feed_watchdog_failsafe.sv =====
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  tick, first_feed, second_feed
// rsp_      out        rsp_valid/rsp_stall  health, action_request, alert, failsafe_active
// csr_      in         csr_valid/csr_ready  csr_index (register), csr_wdata (value)
//
// Each word is held in the input register, is evaluated against the
// watchdog state and lands in the result register. One word per cycle is
// sustained while rsp_stall is low; the state update is a single pass of
// short compare/increment logic. Reset (synchronous) empties both registers,
// zeroes ages, counter, health and failsafe, and loads the register defaults.
// A stalled result holds the input register, which then stalls req_.
`default_nettype none

module dual_feed_watchdog_failsafe (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_tick,
   input  wire logic        req_first_feed,
   input  wire logic        req_second_feed,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_health,
   output logic [1:0]       rsp_action_request,
   output logic             rsp_alert,
   output logic             rsp_failsafe_active,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import dfw_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_take;

   dfw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Move the held word into the result register when that register frees up.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   dfw_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: the input word loads on acceptance only, the result on advance.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.tick        <= req_tick;
         item_ff.first_feed  <= req_first_feed;
         item_ff.second_feed <= req_second_feed;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_health          = rsp_ff.health;
   assign rsp_action_request  = rsp_ff.action_request;
   assign rsp_alert           = rsp_ff.alert;
   assign rsp_failsafe_active = rsp_ff.failsafe_active;

endmodule

`default_nettype wire
